### rtl/core/cssk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cssk_pkg
// Shared types and constants for the cosine-similarity top-K search.
// ----------------------------------------------------------------------------
package cssk_pkg;
    localparam int MAX_DIM_DEF  = 1024;
    localparam int MAX_BEST_DEF = 16;

    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_RECORD = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic CFG_MASK  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    localparam logic signed [15:0] SCORE_ONE = 16'sd16384;

    typedef struct packed {
        logic [31:0]        id;
        logic [2:0]         rtype;
        logic signed [15:0] score;
    } entry_t;

    // control to the cell row
    typedef struct packed {
        logic   ins;     // insert candidate
        logic   hit;     // candidate lands inside K
        logic   shift;   // shift out towards cell 0 (readout)
        logic   clr;     // clear fill
        entry_t cand;
    } row_ctl_t;
endpackage
`default_nettype wire

### rtl/core/cosine_similarity_top_k_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cosine_similarity_top_k_search
// Query load, record scoring and a row of rank cells holding the K best.
// ----------------------------------------------------------------------------
// channel  dir  fields (low bit up)
// s_axis   in   tdata: op, element_value, record_id, record_type; tlast
// m_axis   out  tdata: result_id, result_type, similarity; tuser: no_results
// cfg      in   wr_en, wr_index, wr_data
// A query element is stored as it is accepted (up to MAX_DIM); a record element
// is accepted, then accumulated in M_RD with the query element read from memory.
// A record's last element starts the scorer if a query is loaded and the mask
// admits its type: square-root and division steps, then insertion into the row.
// A finish sends the results in turn from cell 0; each waits while m_axis_tready is low.
// Reset is synchronous; the query memory needs no clearing.
// ----------------------------------------------------------------------------
module cosine_similarity_top_k_search #(
    parameter int MAX_DIM  = cssk_pkg::MAX_DIM_DEF,
    parameter int MAX_BEST = cssk_pkg::MAX_BEST_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // op[1:0], element_value[17:2], record_id[49:18], record_type[52:50]
    input  wire logic [55:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // result_id[31:0], result_type[34:32], similarity[50:35]
    output logic [55:0]      m_axis_tdata,
    // no_results
    output logic             m_axis_tuser,
    output logic             m_axis_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_index,
    input  wire logic [7:0]  cfg_wr_data
);
    localparam int AW = $clog2(MAX_DIM);
    localparam int LW = $clog2(MAX_DIM + 2);
    localparam int KW = $clog2(MAX_BEST + 1);
    localparam logic [1:0] PH_IDLE = 2'd0, PH_QUERY = 2'd1, PH_RECORD = 2'd2;
    localparam logic [2:0] M_RUN = 3'd0, M_RD = 3'd1, M_SC = 3'd2,
                           M_INS = 3'd3, M_OUT = 3'd4;

    logic [7:0]  mask_reg;
    logic [4:0]  kcfg_reg;
    logic [1:0]  ph_reg;
    logic [2:0]  md_reg;
    logic [LW-1:0] qlen_reg, cnt_reg;
    logic [47:0] qn_reg, rn_reg;
    logic signed [47:0] dot_reg;
    logic [31:0] id_reg;
    logic [2:0]  ty_reg;
    logic signed [15:0] qmem [MAX_DIM];
    logic signed [15:0] qrd_reg, ev_reg;
    logic        use_reg;
    logic [KW-1:0] outn_reg, outi_reg;
    logic        outempty_reg;
    logic        sc_start_reg;

    logic [1:0]  op;
    logic signed [15:0] ev;
    logic        acc;
    logic [KW-1:0] keff;
    logic        sc_done;
    logic signed [15:0] sc_val;
    logic signed [31:0] sq, prod, evsq;
    logic        fill_match, zero_res;

    assign op  = s_axis_tdata[1:0];
    assign ev  = $signed(s_axis_tdata[17:2]);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (md_reg == M_RUN);
    assign keff = (int'(kcfg_reg) > MAX_BEST) ? KW'(MAX_BEST) : KW'(kcfg_reg);
    assign sq = ev_reg * ev_reg;
    assign prod = qrd_reg * ev_reg;
    assign evsq = ev * ev;

    cssk_pkg::row_ctl_t ctl;
    logic [MAX_BEST:0]   cv;
    logic [MAX_BEST-1:0] cb;
    cssk_pkg::entry_t    ce [MAX_BEST+1];

    assign cv[MAX_BEST] = 1'b0;
    assign ce[MAX_BEST] = '0;

    logic [MAX_BEST-1:0] upv, upb;
    cssk_pkg::entry_t    upe [MAX_BEST];
    assign upv[0] = 1'b0;
    assign upb[0] = 1'b1;
    assign upe[0] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_BEST; g++) begin : g_cell
            if (g > 0) begin : g_up
                assign upv[g] = cv[g-1];
                assign upb[g] = cb[g-1];
                assign upe[g] = ce[g-1];
            end
            cssk_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl),
                .en       (KW'(g) < keff),
                .up_valid (upv[g]),
                .up_beats (upb[g]),
                .up_entry (upe[g]),
                .dn_valid (cv[g+1]),
                .dn_entry (ce[g+1]),
                .valid    (cv[g]),
                .beats    (cb[g]),
                .entry    (ce[g])
            );
        end
    endgenerate

    logic hit;
    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < MAX_BEST; i++) begin
            if (!cb[i] && (KW'(i) < keff)) hit = 1'b1;
        end
    end

    assign ctl.cand.id    = id_reg;
    assign ctl.cand.rtype = ty_reg;
    assign ctl.cand.score = sc_val;
    assign ctl.ins   = (md_reg == M_INS);
    assign ctl.hit   = hit;
    assign ctl.shift = (md_reg == M_OUT) && m_axis_tready && !outempty_reg;
    assign ctl.clr   = (md_reg == M_OUT) && m_axis_tready &&
                       (outempty_reg || (outi_reg + KW'(1) == outn_reg));

    assign fill_match = (cnt_reg == qlen_reg);
    assign zero_res = !fill_match || (qn_reg == 48'd0) || (rn_reg == 48'd0);

    cssk_score u_score (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sc_start_reg),
        .zero_res (zero_res),
        .qn       (qn_reg),
        .rn       (rn_reg),
        .dot      (dot_reg),
        .done     (sc_done),
        .score    (sc_val)
    );

    logic [KW-1:0] nvalid;
    always_comb begin
        nvalid = '0;
        for (int i = 0; i < MAX_BEST; i++) begin
            if (cv[i] && (KW'(i) < keff)) nvalid = nvalid + KW'(1);
        end
    end

    assign m_axis_tvalid = (md_reg == M_OUT);
    assign m_axis_tdata  = outempty_reg ? 56'd0
                         : {5'd0, ce[0].score, ce[0].rtype, ce[0].id};
    assign m_axis_tuser  = outempty_reg;
    assign m_axis_tlast  = outempty_reg || (outi_reg + KW'(1) == outn_reg);

    always_ff @(posedge aclk) begin
        if (acc && op == cssk_pkg::OP_QUERY && (ph_reg != PH_QUERY || qlen_reg < LW'(MAX_DIM))) begin
            qmem[(ph_reg != PH_QUERY) ? AW'(0) : qlen_reg[AW-1:0]] <= ev;
        end
        qrd_reg <= qmem[(ph_reg != PH_RECORD) ? AW'(0) : cnt_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= 8'd0;
            kcfg_reg <= 5'd5;
            ph_reg <= PH_IDLE;
            md_reg <= M_RUN;
            qlen_reg <= '0;
            qn_reg <= '0;
            rn_reg <= '0;
            dot_reg <= '0;
            cnt_reg <= '0;
            sc_start_reg <= 1'b0;
            outi_reg <= '0;
            outn_reg <= '0;
            outempty_reg <= 1'b0;
        end else begin
            sc_start_reg <= 1'b0;
            if (cfg_wr_en) begin
                if (cfg_wr_index == cssk_pkg::CFG_MASK) mask_reg <= cfg_wr_data;
                else kcfg_reg <= cfg_wr_data[4:0];
            end
            unique case (md_reg)
                M_RUN: begin
                    if (acc) begin
                        if (op == cssk_pkg::OP_QUERY) begin
                            if (ph_reg != PH_QUERY) begin
                                qlen_reg <= LW'(1);
                                qn_reg <= 48'(evsq);
                            end else if (qlen_reg < LW'(MAX_DIM)) begin
                                qlen_reg <= qlen_reg + LW'(1);
                                qn_reg <= qn_reg + 48'(evsq);
                            end
                            ph_reg <= s_axis_tlast ? PH_IDLE : PH_QUERY;
                        end else if (op == cssk_pkg::OP_RECORD) begin
                            if (ph_reg != PH_RECORD) begin
                                cnt_reg <= '0;
                                dot_reg <= '0;
                                rn_reg <= '0;
                            end
                            ev_reg <= ev;
                            use_reg <= s_axis_tlast;
                            id_reg <= s_axis_tdata[49:18];
                            ty_reg <= s_axis_tdata[52:50];
                            ph_reg <= s_axis_tlast ? PH_IDLE : PH_RECORD;
                            md_reg <= M_RD;
                        end else if (op == cssk_pkg::OP_FINISH) begin
                            ph_reg <= PH_IDLE;
                            outi_reg <= '0;
                            outn_reg <= nvalid;
                            outempty_reg <= (nvalid == '0);
                            md_reg <= M_OUT;
                        end
                    end
                end
                M_RD: begin
                    if (cnt_reg < LW'(MAX_DIM)) begin
                        if (cnt_reg < qlen_reg) dot_reg <= dot_reg + 48'(prod);
                        rn_reg <= rn_reg + 48'(sq);
                    end
                    if (cnt_reg <= LW'(MAX_DIM)) cnt_reg <= cnt_reg + LW'(1);
                    if (use_reg && qlen_reg != '0 &&
                        (mask_reg == 8'd0 || mask_reg[ty_reg])) begin
                        sc_start_reg <= 1'b1;
                        md_reg <= M_SC;
                    end else begin
                        md_reg <= M_RUN;
                    end
                end
                M_SC: if (sc_done) md_reg <= M_INS;
                M_INS: md_reg <= M_RUN;
                M_OUT: begin
                    if (m_axis_tready) begin
                        outi_reg <= outi_reg + KW'(1);
                        if (ctl.clr) md_reg <= M_RUN;
                    end
                end
                default: md_reg <= M_RUN;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken during readout");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("empty result not last");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (md_reg == M_INS) |-> $past(sc_done))
        else $error("insert without score");
endmodule
`default_nettype wire

### rtl/core/cssk_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cssk_cell
// One rank slot of the sorted list; takes the candidate or its upper neighbour.
// ----------------------------------------------------------------------------
module cssk_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cssk_pkg::row_ctl_t ctl,
    input  wire logic              en,         // slot lies inside K
    input  wire logic              up_valid,
    input  wire logic              up_beats,   // upper cell outranks candidate
    input  wire cssk_pkg::entry_t  up_entry,
    input  wire logic              dn_valid,
    input  wire cssk_pkg::entry_t  dn_entry,
    output logic                   valid,
    output logic                   beats,
    output cssk_pkg::entry_t       entry
);
    logic             valid_reg, valid_next;
    cssk_pkg::entry_t entry_reg, entry_next;

    assign beats = valid_reg && (entry_reg.score >= ctl.cand.score);
    assign valid = valid_reg;
    assign entry = entry_reg;

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctl.clr) begin
            valid_next = 1'b0;
        end else if (ctl.shift) begin
            valid_next = dn_valid;
            entry_next = dn_entry;
        end else if (ctl.ins) begin
            if (!en) begin
                if (ctl.hit) valid_next = 1'b0;
            end else if (!beats) begin
                if (up_beats) begin
                    valid_next = 1'b1;
                    entry_next = ctl.cand;
                end else if (up_valid) begin
                    valid_next = 1'b1;
                    entry_next = up_entry;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end
endmodule
`default_nettype wire

### rtl/core/cssk_score.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cssk_score
// Multi-cycle scorer: two scaled square roots, a multiply and a long division.
// ----------------------------------------------------------------------------
module cssk_score (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic                      zero_res,
    input  wire logic [47:0]               qn,
    input  wire logic [47:0]               rn,
    input  wire logic signed [47:0]        dot,
    output logic                           done,
    output logic signed [15:0]             score
);
    localparam logic [3:0] S_IDLE = 4'd0, S_NQ = 4'd1, S_SQ = 4'd2, S_NR = 4'd3,
                           S_SR = 4'd4, S_ML = 4'd5, S_DV = 4'd6, S_EN = 4'd7;

    logic [3:0]  st_reg, st_next;
    logic [63:0] n_reg, n_next, r_reg, r_next, b_reg, b_next;
    logic [5:0]  e_reg, e_next;
    logic [6:0]  steps_reg, steps_next;
    logic [31:0] sa_reg, sa_next, sb_reg, sb_next;
    logic [63:0] d_reg, d_next, q_reg, q_next, rem_reg, rem_next;
    logic        neg_reg, neg_next;
    logic signed [15:0] score_reg, score_next;
    logic        done_reg, done_next;
    logic [64:0] rs;
    logic [63:0] qs, qr;

    assign done  = done_reg;
    assign score = score_reg;

    always_comb begin
        st_next = st_reg; n_next = n_reg; r_next = r_reg; b_next = b_reg;
        e_next = e_reg; steps_next = steps_reg; sa_next = sa_reg; sb_next = sb_reg;
        d_next = d_reg; q_next = q_reg; rem_next = rem_reg; neg_next = neg_reg;
        score_next = score_reg; done_next = 1'b0;
        rs = 65'd0; qs = 64'd0; qr = 64'd0;
        unique case (st_reg)
            S_IDLE: begin
                if (start) begin
                    if (zero_res) begin
                        score_next = 16'sd0;
                        done_next  = 1'b1;
                    end else begin
                        n_next = {16'd0, qn};
                        e_next = 6'd0;
                        neg_next = dot[47];
                        rem_next = dot[47] ? 64'(-{{16{dot[47]}}, dot})
                                           : {16'd0, dot};
                        st_next = S_NQ;
                    end
                end
            end
            S_NQ, S_NR: begin
                if (n_reg < (64'd1 << 60)) begin
                    n_next = n_reg << 2;
                    e_next = e_reg + 6'd1;
                end else begin
                    r_next = 64'd0;
                    b_next = 64'd1 << 62;
                    st_next = (st_reg == S_NQ) ? S_SQ : S_SR;
                end
            end
            S_SQ, S_SR: begin
                if (b_reg == 64'd0) begin
                    if (st_reg == S_SQ) begin
                        sa_next = r_reg[31:0];
                        n_next = {16'd0, rn};
                        st_next = S_NR;
                    end else begin
                        sb_next = r_reg[31:0];
                        st_next = S_ML;
                    end
                end else begin
                    if (n_reg >= r_reg + b_reg) begin
                        n_next = n_reg - (r_reg + b_reg);
                        r_next = (r_reg >> 1) + b_reg;
                    end else begin
                        r_next = r_reg >> 1;
                    end
                    b_next = b_reg >> 2;
                end
            end
            S_ML: begin
                d_next = sa_reg * sb_reg;
                // magnitude < 2^47 < d (d >= 2^60), so quotient starts at 0
                q_next = 64'd0;
                steps_next = 7'd15 + {1'b0, e_reg};
                st_next = S_DV;
            end
            S_DV: begin
                if (steps_reg == 7'd0) begin
                    st_next = S_EN;
                end else begin
                    rs = {rem_reg, 1'b0};
                    qs = {q_reg[62:0], 1'b0};
                    if (rs >= {1'b0, d_reg}) begin
                        rs = rs - {1'b0, d_reg};
                        qs = qs | 64'd1;
                    end
                    if (qs > (64'd1 << 40)) qs = 64'd1 << 40;
                    rem_next = rs[63:0];
                    q_next = qs;
                    steps_next = steps_reg - 7'd1;
                end
            end
            S_EN: begin
                qr = (q_reg + 64'd1) >> 1;
                if (qr > 64'd16384) qr = 64'd16384;
                score_next = neg_reg ? -$signed(qr[15:0]) : $signed(qr[15:0]);
                done_next = 1'b1;
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            done_reg <= done_next;
        end
        n_reg <= n_next; r_reg <= r_next; b_reg <= b_next; e_reg <= e_next;
        steps_reg <= steps_next; sa_reg <= sa_next; sb_reg <= sb_next;
        d_reg <= d_next; q_reg <= q_next; rem_reg <= rem_next;
        neg_reg <= neg_next; score_reg <= score_next;
    end
endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine-similarity top-K search testbench
// Streams queries, records and finishes into the block with random idling on
// both sides. A behavioural scorer ranks every record that the type mask admits
// and keeps the expected list; each result item is checked field by field against it.
// ----------------------------------------------------------------------------
module tb;
    localparam int MAXD = 1024;
    localparam int MAXB = 16;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [31:0]        id;
        logic [2:0]         rtype;
        logic signed [15:0] score;
        logic               empty;
        logic               last;
    } rank_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_index = 1'b0;
    logic [7:0]  cfg_wr_data = '0;

    cosine_similarity_top_k_search dut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    // scorer state
    logic [7:0]         mask_q;
    logic [4:0]         k_q;
    logic signed [15:0] qvec [MAXD];
    int unsigned        qlen;
    logic [63:0]        qnorm, rnorm;
    logic signed [63:0] dot;
    int unsigned        ecount;
    logic [31:0]        rank_id [MAXB];
    logic [2:0]         rank_type [MAXB];
    int                 rank_score [MAXB];
    int unsigned        fill;
    int                 phase;   // 0 idle, 1 query, 2 record

    rank_item_t  ranked_q [$];
    int          errors = 0;
    int          stall = 0;
    bit          rx_busy = 1'b1;
    bit          rec_started = 1'b0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int cosine_score();
        logic [63:0] na, nb, sa, sb, d, mag, q, r;
        int unsigned ea, eb;
        bit neg;
        if (ecount != qlen || qlen == 0 || qnorm == 0 || rnorm == 0) return 0;
        na = qnorm; nb = rnorm; ea = 0; eb = 0;
        while (na < (64'd1 << 60)) begin na <<= 2; ea++; end
        while (nb < (64'd1 << 60)) begin nb <<= 2; eb++; end
        sa = root_floor(na);
        sb = root_floor(nb);
        d = sa * sb;
        neg = dot < 0;
        mag = neg ? -dot : dot;
        q = mag / d;
        r = mag % d;
        for (int i = 0; i < 15 + ea + eb; i++) begin
            r <<= 1;
            q <<= 1;
            if (r >= d) begin r -= d; q |= 1; end
            if (q > (64'd1 << 40)) q = 64'd1 << 40;
        end
        q = (q + 1) >> 1;
        if (q > 16384) q = 16384;
        return neg ? -int'(q) : int'(q);
    endfunction

    function automatic int unsigned eff_k();
        return (k_q > MAXB) ? MAXB : k_q;
    endfunction

    function automatic void rank_insert(input logic [31:0] id, input logic [2:0] t,
                                        input int sc);
        int unsigned k, n, p;
        k = eff_k();
        n = (fill < k) ? fill : k;
        p = 0;
        while (p < n && rank_score[p] >= sc) p++;
        if (p >= k) return;
        if (n == k) n = k - 1;
        for (int unsigned i = n; i > p; i--) begin
            rank_id[i] = rank_id[i-1];
            rank_type[i] = rank_type[i-1];
            rank_score[i] = rank_score[i-1];
        end
        rank_id[p] = id;
        rank_type[p] = t;
        rank_score[p] = sc;
        fill = n + 1;
    endfunction

    function automatic void predict(input logic [1:0] op, input logic signed [15:0] v,
                                    input logic last, input logic [31:0] id,
                                    input logic [2:0] t);
        int unsigned n;
        rank_item_t it;
        case (op)
            cssk_pkg::OP_QUERY: begin
                if (phase != 1) begin qlen = 0; qnorm = 0; phase = 1; end
                if (qlen < MAXD) begin
                    qvec[qlen] = v;
                    qnorm += 64'(longint'(v) * longint'(v));
                    qlen++;
                end
                if (last) phase = 0;
            end
            cssk_pkg::OP_RECORD: begin
                if (phase != 2) begin ecount = 0; dot = 0; rnorm = 0; phase = 2; end
                if (ecount < MAXD) begin
                    if (ecount < qlen) dot += longint'(qvec[ecount]) * longint'(v);
                    rnorm += 64'(longint'(v) * longint'(v));
                end
                if (ecount <= MAXD) ecount++;
                if (last) begin
                    phase = 0;
                    if (qlen != 0 && (mask_q == 0 || mask_q[t]))
                        rank_insert(id, t, cosine_score());
                end
            end
            cssk_pkg::OP_FINISH: begin
                phase = 0;
                n = (fill < eff_k()) ? fill : eff_k();
                if (n == 0) begin
                    it = '{id: 0, rtype: 0, score: 0, empty: 1, last: 1};
                    ranked_q.push_back(it);
                end
                for (int unsigned i = 0; i < n; i++) begin
                    it.id = rank_id[i];
                    it.rtype = rank_type[i];
                    it.score = 16'(rank_score[i]);
                    it.empty = 0;
                    it.last = (i + 1 == n);
                    ranked_q.push_back(it);
                end
                fill = 0;
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input logic signed [15:0] v,
                             input logic last, input logic [31:0] id, input logic [2:0] t);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 1) == 0) gap = 0;
        repeat (gap) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b0, t, id, v, op};
        s_axis_tlast <= last;
        do @(posedge aclk); while (!s_axis_tready);
        predict(op, v, last, id, t);
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (ranked_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic idx, input logic [7:0] val);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == cssk_pkg::CFG_MASK) mask_q = val;
        else k_q = val[4:0];
    endtask

    function automatic logic signed [15:0] rnd_elem();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sd0;
            default: return 16'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    task automatic send_query(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_item(cssk_pkg::OP_QUERY, rnd_elem(), i + 1 == len, $urandom, 3'($urandom));
    endtask

    task automatic send_record(input int unsigned len, input logic [2:0] t);
        logic [31:0] id;
        id = $urandom;
        for (int unsigned i = 0; i < len; i++)
            send_item(cssk_pkg::OP_RECORD, rnd_elem(), i + 1 == len, id, t);
    endtask

    task automatic send_finish();
        send_item(cssk_pkg::OP_FINISH, 16'($urandom), 1'($urandom_range(0, 1)), $urandom,
                  3'($urandom));
    endtask

    task automatic test_directed();
        send_finish();                          // empty list
        send_record(3, 3'd0);                   // no query yet
        send_finish();
        send_item(cssk_pkg::OP_QUERY, 16'sh7fff, 1'b0, 32'd0, 3'd0);
        send_item(cssk_pkg::OP_QUERY, 16'sh8000, 1'b0, 32'd0, 3'd0);
        send_item(cssk_pkg::OP_QUERY, 16'sh4000, 1'b1, 32'd0, 3'd0);
        send_item(cssk_pkg::OP_RECORD, 16'sh7fff, 1'b0, 32'hffffffff, 3'd7);
        send_item(cssk_pkg::OP_RECORD, 16'sh8000, 1'b0, 32'hffffffff, 3'd7);
        send_item(cssk_pkg::OP_RECORD, 16'sh4000, 1'b1, 32'hffffffff, 3'd7);
        send_item(cssk_pkg::OP_RECORD, 16'sh8001, 1'b0, 32'd0, 3'd0);
        send_item(cssk_pkg::OP_RECORD, 16'sh7fff, 1'b0, 32'd0, 3'd0);
        send_item(cssk_pkg::OP_RECORD, 16'shc000, 1'b1, 32'd0, 3'd0);
        send_record(2, 3'd3);                   // length differs
        send_item(cssk_pkg::OP_RECORD, 16'sd0, 1'b0, 32'd5, 3'd1);
        send_item(cssk_pkg::OP_RECORD, 16'sd0, 1'b0, 32'd5, 3'd1);
        send_item(cssk_pkg::OP_RECORD, 16'sd0, 1'b1, 32'd5, 3'd1);   // zero norm
        send_item(cssk_pkg::OP_NONE, 16'sh1234, 1'b1, 32'd1, 3'd1);  // undefined operation
        send_item(cssk_pkg::OP_RECORD, 16'sh0100, 1'b0, 32'd9, 3'd2); // partial record
        send_finish();
    endtask

    task automatic test_unfinished_query();
        send_item(cssk_pkg::OP_QUERY, 16'sh2000, 1'b0, 32'd0, 3'd0);
        send_item(cssk_pkg::OP_QUERY, 16'sh1000, 1'b0, 32'd0, 3'd0);
        send_record(2, 3'd4);                   // closes the query at length 2
        send_record(2, 3'd4);
        send_item(cssk_pkg::OP_QUERY, 16'sh0800, 1'b0, 32'd0, 3'd0);
        send_finish();
        send_record(1, 3'd5);
        send_finish();
    endtask

    task automatic test_random(input int unsigned budget);
        int unsigned sent, dim, len;
        sent = 0;
        while (sent < budget) begin
            dim = $urandom_range(1, 6);
            send_query(dim);
            sent += dim;
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 9))
                    0: len = $urandom_range(1, 8);
                    1: begin
                        send_item(cssk_pkg::OP_QUERY, rnd_elem(), 1'b0, 32'd0, 3'd0);
                        len = dim;
                    end
                    default: len = dim;
                endcase
                send_record(len, 3'($urandom));
                sent += len;
            end
            if ($urandom_range(0, 9) == 0)
                send_item(cssk_pkg::OP_NONE, rnd_elem(), 1'b1, $urandom, 3'd0);
            send_finish();
            sent++;
        end
    endtask

    task automatic test_settings();
        write_cfg(cssk_pkg::CFG_COUNT, 8'd16);
        write_cfg(cssk_pkg::CFG_MASK, 8'hff);
        test_random(30);
        write_cfg(cssk_pkg::CFG_COUNT, 8'd31);  // above the maximum
        write_cfg(cssk_pkg::CFG_MASK, 8'h81);
        test_random(20);
        write_cfg(cssk_pkg::CFG_COUNT, 8'd0);
        test_random(10);
        write_cfg(cssk_pkg::CFG_COUNT, 8'd1);
        write_cfg(cssk_pkg::CFG_MASK, 8'h00);
        test_random(20);
        write_cfg(cssk_pkg::CFG_COUNT, 8'd8);
        write_cfg(cssk_pkg::CFG_MASK, 8'h5a);
        send_query(3);
        repeat (10) send_record(3, 3'($urandom));
        write_cfg(cssk_pkg::CFG_COUNT, 8'd3);   // lowered mid-search
        send_finish();
    endtask

    // result side
    initial begin
        rank_item_t w;
        forever begin
            @(negedge aclk);
            m_axis_tready <= ($urandom_range(0, 2) != 0) || rx_busy;
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (ranked_q.size() == 0) begin
                    report("unexpected result", m_axis_tdata, 0);
                end else begin
                    w = ranked_q.pop_front();
                    if (m_axis_tdata[31:0] !== w.id) report("result_id", m_axis_tdata[31:0], w.id);
                    if (m_axis_tdata[34:32] !== w.rtype)
                        report("result_type", m_axis_tdata[34:32], w.rtype);
                    if (m_axis_tdata[50:35] !== w.score)
                        report("similarity", m_axis_tdata[50:35], w.score);
                    if (m_axis_tuser !== w.empty) report("no_results", m_axis_tuser, w.empty);
                    if (m_axis_tlast !== w.last) report("last_result", m_axis_tlast, w.last);
                end
                if ($urandom_range(0, 4) == 0) begin
                    rx_busy = 1'b0;
                    repeat ($urandom_range(0, 10)) begin
                        @(negedge aclk);
                        m_axis_tready <= 1'b0;
                    end
                end else begin
                    rx_busy = $urandom_range(0, 1);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stall <= 0;
        else stall <= stall + 1;
        if (stall >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        mask_q = 0; k_q = 5; qlen = 0; qnorm = 0; rnorm = 0; dot = 0; ecount = 0;
        fill = 0; phase = 0;
        for (int i = 0; i < MAXB; i++) begin
            rank_id[i] = 0; rank_type[i] = 0; rank_score[i] = 0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_unfinished_query();
        test_settings();
        wait_idle();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
